### design/ipv4_five_tuple_extractor_top_assert.svh
// Assertion macros for the IPv4 five-tuple extractor.
// Used by ipv4_five_tuple_extractor_top; expects clk and rst_n in scope.
`ifndef IPV4_FIVE_TUPLE_EXTRACTOR_TOP_ASSERT_SVH
`define IPV4_FIVE_TUPLE_EXTRACTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define V4FT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define V4FT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/v4ft_pkg.sv
// Shared types and constants of the IPv4 five-tuple extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package v4ft_pkg;

  // Frame layout
  localparam int unsigned ETH_TYPE_POS_HI = 12;
  localparam int unsigned ETH_TYPE_POS_LO = 13;
  localparam int unsigned ETH_HDR_LEN     = 14;
  localparam int unsigned IP_HDR_LEN      = 20;
  localparam int unsigned IHL_UNIT_SHIFT  = 2;
  localparam int unsigned PORT_BYTES      = 4;
  localparam int unsigned UDP_HDR_LEN     = 8;
  localparam int unsigned TCP_HDR_LEN     = 20;

  // Header field codes
  localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;

  // Header byte offsets inside the IP header
  localparam int unsigned IP_PROTO_IDX = 9;
  localparam int unsigned IP_SRC_IDX   = 12;
  localparam int unsigned IP_DST_IDX   = 16;

  // Command queue between front and back
  localparam int unsigned CMD_Q_DEPTH = 4;
  localparam int unsigned CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

  localparam int unsigned L4_OFS_W = 7;   // 14 + 15*4 + 20 fits
  localparam int unsigned HDR_IDX_W = 5;

  typedef logic [7:0] byte_t;

  // One classified frame byte
  typedef struct packed {
    byte_t                 data;
    logic                  eth_wr;
    logic                  hdr_wr;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic                  port_wr;
    logic                  last;
    logic                  len_ok;
    logic                  udp_fit;
    logic                  tcp_fit;
  } cmd_t;

  // Back-end activity, for checking at the top level
  typedef struct packed {
    logic cmd_take;
    logic cmd_last;
    logic rec_load;
  } back_stat_t;

endpackage

`default_nettype wire

### design/ipv4_five_tuple_extractor_top.sv
// IPv4 five-tuple extractor: Ethernet frame bytes in, one address/port record out.
// Depends on v4ft_pkg, v4ft_front, v4ft_cmd_fifo, v4ft_back and the assert header.
//
// Usage:
//   Input channel: drive in_frame_byte and in_last_byte with push; a byte is
//   taken at a clock edge where push is high and full is low. One byte per
//   cycle is sustained while full is low; the front end classes bytes by position.
//   Result channel: while empty is low the record is on the out_ ports; pop
//   with empty low takes it. Frames that are short, not IPv4, or lack a full
//   20-byte IP header give no record. Ports are zero unless UDP or TCP with the
//   whole L4 header inside the frame.
//   Output: the back end registers the record when it takes the last byte.
//   Throughput: the back end drains one command per cycle unless stalled.
//   Stall: an unpopped record holds the next frame's last byte in the back end;
//   the four-entry command queue then fills and full rises until pop.
//   Reset: synchronous active-low rst_n clears the position, captures, queue
//   and valid flag; the IHL, header store and record fields hold no reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_five_tuple_extractor_top_assert.svh"

module ipv4_five_tuple_extractor_top #(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  output logic         full,
  input  wire [7:0]    in_frame_byte,
  input  wire          in_last_byte,
  output logic         empty,
  input  wire          pop,
  output logic [31:0]  out_source_address,
  output logic [31:0]  out_dest_address,
  output logic [15:0]  out_source_port,
  output logic [15:0]  out_dest_port,
  output logic [7:0]   out_protocol_number
);
  import v4ft_pkg::*;

  cmd_t       front_cmd;
  cmd_t       back_cmd;
  logic       q_full, q_empty;
  logic       in_take;
  logic       cmd_take;
  back_stat_t stat;

  assign full    = q_full;
  assign in_take = push && !q_full;

  v4ft_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_frame_byte(in_frame_byte),
    .in_last_byte (in_last_byte),
    .cmd          (front_cmd)
  );

  v4ft_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_take),
    .wr_data(front_cmd),
    .q_full (q_full),
    .rd_en  (cmd_take),
    .rd_data(back_cmd),
    .q_empty(q_empty)
  );

  v4ft_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (back_cmd),
    .cmd_avail          (!q_empty),
    .cmd_take           (cmd_take),
    .empty              (empty),
    .pop                (pop),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_protocol_number(out_protocol_number),
    .stat               (stat)
  );

  // Checks on the front/back coupling
  `V4FT_ASSERT_SAME(a_take_needs_entry, stat.cmd_take, !q_empty, "command taken from empty queue")
  `V4FT_ASSERT_SAME(a_rec_on_last, stat.rec_load, stat.cmd_take && stat.cmd_last, "record without frame end")
  `V4FT_ASSERT_NEXT(a_rec_shows, stat.rec_load, !empty, "loaded record not shown")

endmodule

`default_nettype wire

### design/v4ft_front.sv
// Front end: tracks the byte position and IHL and classifies each byte.
// Depends on v4ft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_front #(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_take,
  input  wire v4ft_pkg::byte_t in_frame_byte,
  input  wire               in_last_byte,
  output v4ft_pkg::cmd_t    cmd
);
  import v4ft_pkg::*;

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]    ihl_r, ihl_nxt;
  logic [3:0]    ihl_cur;
  logic [PW-1:0] l4_ofs;
  logic [PW-1:0] len;
  logic          in_range;

  // Pick the IHL nibble, forwarding it on the first IP header byte
  always_comb begin
    in_range = (pos_r < POS_MAX);
    ihl_cur  = (pos_r == PW'(ETH_HDR_LEN)) ? in_frame_byte[3:0] : ihl_r;
    l4_ofs   = PW'(L4_OFS_W'(ETH_HDR_LEN) +
                   (L4_OFS_W'(ihl_cur) << IHL_UNIT_SHIFT));
    len      = in_range ? pos_r + PW'(1) : pos_r;
  end

  // Classify the byte
  always_comb begin
    cmd.data    = in_frame_byte;
    cmd.eth_wr  = in_range && (pos_r == PW'(ETH_TYPE_POS_HI) ||
                               pos_r == PW'(ETH_TYPE_POS_LO));
    cmd.hdr_wr  = in_range && (pos_r >= PW'(ETH_HDR_LEN)) &&
                  (pos_r < PW'(ETH_HDR_LEN + IP_HDR_LEN));
    cmd.hdr_idx = HDR_IDX_W'(pos_r - PW'(ETH_HDR_LEN));
    cmd.port_wr = in_range && (pos_r >= PW'(ETH_HDR_LEN)) && (pos_r >= l4_ofs) &&
                  (pos_r < l4_ofs + PW'(PORT_BYTES));
    cmd.last    = in_last_byte;
    cmd.len_ok  = (len >= PW'(ETH_HDR_LEN + IP_HDR_LEN));
    cmd.udp_fit = (l4_ofs + PW'(UDP_HDR_LEN) <= len);
    cmd.tcp_fit = (l4_ofs + PW'(TCP_HDR_LEN) <= len);
  end

  // Advance the position, saturate at the limit, drop it at frame end; track the IHL
  always_comb begin
    pos_nxt = pos_r;
    ihl_nxt = ihl_r;
    if (in_take) begin
      if (pos_r == PW'(ETH_HDR_LEN)) begin
        ihl_nxt = in_frame_byte[3:0];
      end
      if (in_last_byte) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
    ihl_r <= ihl_nxt;
  end

endmodule

`default_nettype wire

### design/v4ft_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on v4ft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_cmd_fifo (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            wr_en,
  input  wire v4ft_pkg::cmd_t wr_data,
  output logic           q_full,
  input  wire            rd_en,
  output v4ft_pkg::cmd_t rd_data,
  output logic           q_empty
);
  import v4ft_pkg::*;

  cmd_t                mem_r [CMD_Q_DEPTH];
  logic [CMD_Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_Q_AW:0]   count_r, count_nxt;
  logic                do_wr, do_rd;

  always_comb begin
    q_full     = (count_r == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
    q_empty    = (count_r == '0);
    do_wr      = wr_en && !q_full;
    do_rd      = rd_en && !q_empty;
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (CMD_Q_AW+1)'(do_wr) - (CMD_Q_AW+1)'(do_rd);
    rd_data    = mem_r[rd_ptr_r];
  end

  // Store the entry and advance pointers
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### design/v4ft_back.sv
// Back end: applies the captures and builds the record at frame end.
// Depends on v4ft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire v4ft_pkg::cmd_t cmd,
  input  wire                 cmd_avail,
  output logic                cmd_take,
  output logic                empty,
  input  wire                 pop,
  output logic [31:0]         out_source_address,
  output logic [31:0]         out_dest_address,
  output logic [15:0]         out_source_port,
  output logic [15:0]         out_dest_port,
  output logic [7:0]          out_protocol_number,
  output v4ft_pkg::back_stat_t stat
);
  import v4ft_pkg::*;

  logic [15:0] eth_r, eth_nxt;
  logic [31:0] port_r, port_nxt;
  byte_t       hdr_r [IP_HDR_LEN];
  byte_t       hdr_nxt [IP_HDR_LEN];
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] src_r, dst_r;
  logic [15:0] sport_r, dport_r;
  logic [7:0]  proto_r;
  logic        slot_free;
  logic        rec_load;
  logic        ports_ok;

  // Take a command unless a frame end waits on a full output slot
  always_comb begin
    slot_free = !out_valid_r || pop;
    cmd_take  = cmd_avail && (!cmd.last || slot_free);
  end

  // Next capture state, with the current byte folded in
  always_comb begin
    eth_nxt  = cmd.eth_wr  ? {eth_r[7:0], cmd.data}   : eth_r;
    port_nxt = cmd.port_wr ? {port_r[23:0], cmd.data} : port_r;
    for (int i = 0; i < IP_HDR_LEN; i++) begin
      hdr_nxt[i] = (cmd.hdr_wr && cmd.hdr_idx == HDR_IDX_W'(i)) ? cmd.data : hdr_r[i];
    end
    ports_ok = (hdr_nxt[IP_PROTO_IDX] == PROTO_UDP && cmd.udp_fit) ||
               (hdr_nxt[IP_PROTO_IDX] == PROTO_TCP && cmd.tcp_fit);
    rec_load = cmd_take && cmd.last && cmd.len_ok && (eth_nxt == ETHTYPE_IPV4);
    out_valid_nxt = rec_load || (out_valid_r && !pop);
  end

  // Update captures; clear per-frame state at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eth_r       <= '0;
      port_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_take) begin
        if (cmd.last) begin
          eth_r  <= '0;
          port_r <= '0;
        end else begin
          eth_r  <= eth_nxt;
          port_r <= port_nxt;
        end
      end
    end
    if (cmd_take) begin
      for (int i = 0; i < IP_HDR_LEN; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  // Load the result record
  always_ff @(posedge clk) begin
    if (rec_load) begin
      src_r   <= {hdr_nxt[IP_SRC_IDX], hdr_nxt[IP_SRC_IDX+1],
                  hdr_nxt[IP_SRC_IDX+2], hdr_nxt[IP_SRC_IDX+3]};
      dst_r   <= {hdr_nxt[IP_DST_IDX], hdr_nxt[IP_DST_IDX+1],
                  hdr_nxt[IP_DST_IDX+2], hdr_nxt[IP_DST_IDX+3]};
      sport_r <= ports_ok ? port_nxt[31:16] : 16'h0000;
      dport_r <= ports_ok ? port_nxt[15:0]  : 16'h0000;
      proto_r <= hdr_nxt[IP_PROTO_IDX];
    end
  end

  always_comb begin
    empty               = !out_valid_r;
    out_source_address  = src_r;
    out_dest_address    = dst_r;
    out_source_port     = sport_r;
    out_dest_port       = dport_r;
    out_protocol_number = proto_r;
    stat.cmd_take       = cmd_take;
    stat.cmd_last       = cmd.last;
    stat.rec_load       = rec_load;
  end

endmodule

`default_nettype wire
